/* rtl/core/euler_to_quaternion_unit_macros.svh */
// ----------------------------------------------------------------------------
// Euler to quaternion unit assertion macros
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_TO_QUATERNION_UNIT_MACROS_SVH

`ifndef SYNTH
`define E2Q_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define E2Q_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define E2Q_ASSERT_IMP(label, ante, cons)
`define E2Q_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* rtl/core/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W           = 16;
  localparam int OUT_W             = 16;
  localparam int Q_W               = 32;
  localparam int MAG_W             = 14;
  localparam int LANES             = 3;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF = 15;
  localparam int SUM_W             = 67;
  localparam int P60_W             = 66;
  localparam int P30_W             = 34;

  localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
  localparam logic [MAG_W-1:0]   MAG_MAX      = 14'd11520;

  // pi * 2^30 = RAD_Q * 23040 + RAD_R
  localparam logic [17:0] RAD_Q       = 18'd146408;
  localparam logic [14:0] RAD_R       = 15'd19106;
  localparam logic [27:0] RAD_BIAS    = 28'd11520;
  localparam int          RECIP_PRE   = 9;
  localparam int          RECIP_SHIFT = 26;
  localparam logic [20:0] RECIP_M     = 21'd1491309;

  localparam logic signed [Q_W-1:0] GAIN_Q30 = 32'sh26DD3B6A;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [OUT_W-1:0]   quat_t;
  typedef logic signed [Q_W-1:0]     q30_t;
  typedef logic signed [P30_W-1:0]   p30_t;
  typedef logic signed [P60_W-1:0]   p60_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  function automatic q30_t atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:    return 32'sh3243F6A8;
      5'd1:    return 32'sh1DAC6705;
      5'd2:    return 32'sh0FADBAFC;
      5'd3:    return 32'sh07F56EA6;
      5'd4:    return 32'sh03FEAB76;
      5'd5:    return 32'sh01FFD55B;
      5'd6:    return 32'sh00FFFAAA;
      5'd7:    return 32'sh007FFF55;
      5'd8:    return 32'sh003FFFEA;
      5'd9:    return 32'sh001FFFFD;
      5'd10:   return 32'sh000FFFFF;
      5'd11:   return 32'sh0007FFFF;
      5'd12:   return 32'sh0003FFFF;
      5'd13:   return 32'sh0001FFFF;
      5'd14:   return 32'sh0000FFFF;
      5'd15:   return 32'sh00007FFF;
      5'd16:   return 32'sh00003FFF;
      5'd17:   return 32'sh00001FFF;
      5'd18:   return 32'sh00000FFF;
      5'd19:   return 32'sh000007FF;
      5'd20:   return 32'sh000003FF;
      5'd21:   return 32'sh000001FF;
      5'd22:   return 32'sh000000FF;
      5'd23:   return 32'sh0000007F;
      default: return 32'sh00000000;
    endcase
  endfunction

  // Q30 x Q30 -> Q30, round half up
  function automatic p30_t mul30(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[63:30];
  endfunction

endpackage

/* rtl/core/euler_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// Euler to quaternion unit
// Converts roll, pitch and yaw (degrees, 6 fraction bits) into a ZYX unit
// quaternion (w, x, y, z) through a fully pipelined CORDIC.
//
// Usage:
//   Input channel in_valid / in_stall carries one word of three signed angles.
//   Result channel out_valid / out_stall carries one word of four signed
//   quaternion components with OUT_FRAC_BITS fraction bits, saturated to
//   16 bits.
//   Throughput: one word per cycle while out_stall is low.
//   Pipeline stages, in order: fold, three radian-conversion stages, one
//   CORDIC stage per iteration, cosine sign, two multiply stages, sum,
//   round and saturate.
//   Each stage holds only while its downstream stage is full and held, so
//   bubbles collapse; a stalled output holds its word and in_stall rises only
//   when the first stage is full and cannot advance.
//   Reset clears all valid bits; no words are in flight afterward.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_unit_macros.svh"

module euler_to_quaternion_unit #(
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF,
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  e2q_pkg::angle_t in_roll_deg,
  input  e2q_pkg::angle_t in_pitch_deg,
  input  e2q_pkg::angle_t in_yaw_deg,
  output logic            out_valid,
  input  logic            out_stall,
  output e2q_pkg::quat_t  out_quat_w,
  output e2q_pkg::quat_t  out_quat_x,
  output e2q_pkg::quat_t  out_quat_y,
  output e2q_pkg::quat_t  out_quat_z
);

  localparam int LANES   = e2q_pkg::LANES;
  localparam int MAG_W   = e2q_pkg::MAG_W;
  localparam int NV      = CORDIC_STAGES + 9;
  localparam int ST_LAST = CORDIC_STAGES + 3;
  localparam int ST_SC   = CORDIC_STAGES + 4;
  localparam int ST_P1   = CORDIC_STAGES + 5;
  localparam int ST_P2   = CORDIC_STAGES + 6;
  localparam int ST_SUM  = CORDIC_STAGES + 7;
  localparam int ST_OUT  = CORDIC_STAGES + 8;
  localparam int RND_SH  = 60 - OUT_FRAC_BITS;

  localparam e2q_pkg::sum_t RND     = e2q_pkg::sum_t'(1) <<< (RND_SH - 1);
  localparam e2q_pkg::sum_t SAT_HI  = e2q_pkg::sum_t'(32767);
  localparam e2q_pkg::sum_t SAT_LO  = -e2q_pkg::sum_t'(32768);

  logic [NV-1:0] vld_r;
  logic [NV-1:0] en;

  e2q_pkg::angle_t ang [LANES];

  logic [MAG_W-1:0] mag_nxt  [LANES];
  logic             sgn_nxt  [LANES];
  logic             negc_nxt [LANES];
  logic [MAG_W-1:0] mag_r    [LANES];
  logic             sgn_r    [3][LANES];
  logic             negc_r   [ST_LAST+1][LANES];

  logic [30:0]      mq_r     [LANES];
  logic [27:0]      t_r      [LANES];
  logic [30:0]      mqd_r    [LANES];
  logic [MAG_W-1:0] q_r      [LANES];

  e2q_pkg::q30_t cx_r [CORDIC_STAGES+1][LANES];
  e2q_pkg::q30_t cy_r [CORDIC_STAGES+1][LANES];
  e2q_pkg::q30_t cz_r [CORDIC_STAGES+1][LANES];

  e2q_pkg::q30_t s_r [LANES];
  e2q_pkg::q30_t c_r [LANES];

  e2q_pkg::p30_t crcp_r, srsp_r, srcp_r, crsp_r;
  e2q_pkg::q30_t syd_r, cyd_r;
  e2q_pkg::p60_t pw_r [8];
  e2q_pkg::sum_t sw_r [4];
  e2q_pkg::quat_t quat_r [4];
  e2q_pkg::quat_t quat_nxt [4];

  assign ang[0] = in_roll_deg;
  assign ang[1] = in_pitch_deg;
  assign ang[2] = in_yaw_deg;

  // advance a stage when it is empty or its downstream stage advances
  always_comb begin
    en[NV-1] = ~vld_r[NV-1] | ~out_stall;
    for (int j = NV - 2; j >= 0; j--) begin
      en[j] = ~vld_r[j] | en[j+1];
    end
  end

  assign in_stall  = ~en[0];
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int j = 1; j < NV; j++) begin
        if (en[j]) begin
          vld_r[j] <= vld_r[j-1];
        end
      end
    end
  end

  // fold half angle into [-90, +90] degrees
  always_comb begin
    logic signed [17:0] h;
    for (int l = 0; l < LANES; l++) begin
      h = 18'(ang[l]);
      negc_nxt[l] = 1'b0;
      if (h > e2q_pkg::HALF_TURN) begin
        h = h - e2q_pkg::FULL_TURN;
      end else if (h < -e2q_pkg::HALF_TURN) begin
        h = h + e2q_pkg::FULL_TURN;
      end
      if (h > e2q_pkg::QUARTER_TURN) begin
        h = e2q_pkg::HALF_TURN - h;
        negc_nxt[l] = 1'b1;
      end else if (h < -e2q_pkg::QUARTER_TURN) begin
        h = -e2q_pkg::HALF_TURN - h;
        negc_nxt[l] = 1'b1;
      end
      sgn_nxt[l] = h[17];
      mag_nxt[l] = h[17] ? MAG_W'(-h) : MAG_W'(h);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < LANES; l++) begin
        mag_r[l]     <= mag_nxt[l];
        sgn_r[0][l]  <= sgn_nxt[l];
        negc_r[0][l] <= negc_nxt[l];
      end
    end
    for (int j = 1; j <= ST_LAST; j++) begin
      if (en[j]) begin
        for (int l = 0; l < LANES; l++) begin
          negc_r[j][l] <= negc_r[j-1][l];
        end
      end
    end
    for (int j = 1; j < 3; j++) begin
      if (en[j]) begin
        for (int l = 0; l < LANES; l++) begin
          sgn_r[j][l] <= sgn_r[j-1][l];
        end
      end
    end
  end

  // radians: mag * pi * 2^30 / 23040, rounded
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < LANES; l++) begin
        mq_r[l] <= 31'(32'(mag_r[l]) * 32'(e2q_pkg::RAD_Q));
        t_r[l]  <= 28'(28'(mag_r[l]) * 28'(e2q_pkg::RAD_R)) + e2q_pkg::RAD_BIAS;
      end
    end
    if (en[2]) begin
      for (int l = 0; l < LANES; l++) begin
        mqd_r[l] <= mq_r[l];
        q_r[l]   <= MAG_W'((40'(t_r[l] >> e2q_pkg::RECIP_PRE) * 40'(e2q_pkg::RECIP_M))
                           >> e2q_pkg::RECIP_SHIFT);
      end
    end
    if (en[3]) begin
      for (int l = 0; l < LANES; l++) begin
        cx_r[0][l] <= e2q_pkg::GAIN_Q30;
        cy_r[0][l] <= '0;
        cz_r[0][l] <= sgn_r[2][l] ? -e2q_pkg::q30_t'(mqd_r[l] + 31'(q_r[l]))
                                  :  e2q_pkg::q30_t'(mqd_r[l] + 31'(q_r[l]));
      end
    end
  end

  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        for (int l = 0; l < LANES; l++) begin
          if (!cz_r[k-1][l][e2q_pkg::Q_W-1]) begin
            cx_r[k][l] <= cx_r[k-1][l] - (cy_r[k-1][l] >>> (k - 1));
            cy_r[k][l] <= cy_r[k-1][l] + (cx_r[k-1][l] >>> (k - 1));
            cz_r[k][l] <= cz_r[k-1][l] - e2q_pkg::atan_q30(5'(k - 1));
          end else begin
            cx_r[k][l] <= cx_r[k-1][l] + (cy_r[k-1][l] >>> (k - 1));
            cy_r[k][l] <= cy_r[k-1][l] - (cx_r[k-1][l] >>> (k - 1));
            cz_r[k][l] <= cz_r[k-1][l] + e2q_pkg::atan_q30(5'(k - 1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SC]) begin
      for (int l = 0; l < LANES; l++) begin
        s_r[l] <= cy_r[CORDIC_STAGES][l];
        c_r[l] <= negc_r[ST_LAST][l] ? -cx_r[CORDIC_STAGES][l] : cx_r[CORDIC_STAGES][l];
      end
    end
    if (en[ST_P1]) begin
      crcp_r <= e2q_pkg::mul30(c_r[0], c_r[1]);
      srsp_r <= e2q_pkg::mul30(s_r[0], s_r[1]);
      srcp_r <= e2q_pkg::mul30(s_r[0], c_r[1]);
      crsp_r <= e2q_pkg::mul30(c_r[0], s_r[1]);
      syd_r  <= s_r[2];
      cyd_r  <= c_r[2];
    end
    if (en[ST_P2]) begin
      pw_r[0] <= e2q_pkg::p60_t'(crcp_r) * e2q_pkg::p60_t'(cyd_r);
      pw_r[1] <= e2q_pkg::p60_t'(srsp_r) * e2q_pkg::p60_t'(syd_r);
      pw_r[2] <= e2q_pkg::p60_t'(srcp_r) * e2q_pkg::p60_t'(cyd_r);
      pw_r[3] <= e2q_pkg::p60_t'(crsp_r) * e2q_pkg::p60_t'(syd_r);
      pw_r[4] <= e2q_pkg::p60_t'(crsp_r) * e2q_pkg::p60_t'(cyd_r);
      pw_r[5] <= e2q_pkg::p60_t'(srcp_r) * e2q_pkg::p60_t'(syd_r);
      pw_r[6] <= e2q_pkg::p60_t'(crcp_r) * e2q_pkg::p60_t'(syd_r);
      pw_r[7] <= e2q_pkg::p60_t'(srsp_r) * e2q_pkg::p60_t'(cyd_r);
    end
    if (en[ST_SUM]) begin
      sw_r[0] <= e2q_pkg::sum_t'(pw_r[0]) + e2q_pkg::sum_t'(pw_r[1]);
      sw_r[1] <= e2q_pkg::sum_t'(pw_r[2]) - e2q_pkg::sum_t'(pw_r[3]);
      sw_r[2] <= e2q_pkg::sum_t'(pw_r[4]) + e2q_pkg::sum_t'(pw_r[5]);
      sw_r[3] <= e2q_pkg::sum_t'(pw_r[6]) - e2q_pkg::sum_t'(pw_r[7]);
    end
    if (en[ST_OUT]) begin
      quat_r <= quat_nxt;
    end
  end

  // round and saturate
  always_comb begin
    e2q_pkg::sum_t rr;
    for (int i = 0; i < 4; i++) begin
      rr = (sw_r[i] + RND) >>> RND_SH;
      if (rr > SAT_HI) begin
        quat_nxt[i] = 16'sh7FFF;
      end else if (rr < SAT_LO) begin
        quat_nxt[i] = 16'sh8000;
      end else begin
        quat_nxt[i] = rr[15:0];
      end
    end
  end

  assign out_quat_w = quat_r[0];
  assign out_quat_x = quat_r[1];
  assign out_quat_y = quat_r[2];
  assign out_quat_z = quat_r[3];

  `E2Q_ASSERT_IMP(a_stall_full, in_stall, vld_r[0])
  `E2Q_ASSERT_NXT(a_out_load, vld_r[NV-1] && !out_stall, vld_r[NV-1] == $past(vld_r[NV-2]))
  `E2Q_ASSERT_IMP(a_fold_range, vld_r[0], mag_r[0] <= e2q_pkg::MAG_MAX && mag_r[1] <= e2q_pkg::MAG_MAX && mag_r[2] <= e2q_pkg::MAG_MAX)

endmodule

/* tb/tb_euler_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// Euler to quaternion unit testbench
// Sends roll, pitch and yaw words through the unit under bursty input and a
// patterned output stall, predicts each quaternion with a bit-exact CORDIC
// model and compares every result word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euler_to_quaternion_unit;

  localparam int     RANDOM_WORDS   = 1330;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     TAIL_CYCLES    = 40;
  localparam int     N_STAGES       = e2q_pkg::CORDIC_STAGES_DEF;
  localparam int     N_ATAN         = 24;
  localparam int     OUT_SHIFT      = 60 - e2q_pkg::OUT_FRAC_BITS_DEF;
  localparam longint ANG_HALF       = 23040;
  localparam longint ANG_FULL       = 46080;
  localparam longint ANG_QUARTER    = 11520;
  localparam longint PI_SCALED      = 64'sd3373259426;
  localparam longint CORDIC_K       = 64'sd652032874;
  localparam longint Q15_MAX        = 32767;
  localparam longint Q15_MIN        = -32768;
  localparam longint ARCTAN [N_ATAN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct {
    e2q_pkg::angle_t roll;
    e2q_pkg::angle_t pitch;
    e2q_pkg::angle_t yaw;
    bit              drain;
  } angle_word_t;

  typedef struct {
    e2q_pkg::quat_t w;
    e2q_pkg::quat_t x;
    e2q_pkg::quat_t y;
    e2q_pkg::quat_t z;
  } quat_word_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  e2q_pkg::angle_t in_roll_deg = '0;
  e2q_pkg::angle_t in_pitch_deg = '0;
  e2q_pkg::angle_t in_yaw_deg = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  e2q_pkg::quat_t  out_quat_w;
  e2q_pkg::quat_t  out_quat_x;
  e2q_pkg::quat_t  out_quat_y;
  e2q_pkg::quat_t  out_quat_z;

  angle_word_t angle_feed[$];
  quat_word_t  quat_due[$];
  bit          in_took = 1'b0;
  int          words_in = 0;
  int          words_out = 0;
  int          n_directed = 0;
  int          n_drains = 0;
  int          n_errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_left = 0;
  rx_mode_t    rx_mode = RX_FREE;

  euler_to_quaternion_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_roll_deg  (in_roll_deg),
    .in_pitch_deg (in_pitch_deg),
    .in_yaw_deg   (in_yaw_deg),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_quat_w   (out_quat_w),
    .out_quat_x   (out_quat_x),
    .out_quat_y   (out_quat_y),
    .out_quat_z   (out_quat_z)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void half_angle_trig(input e2q_pkg::angle_t code,
                                          output longint sin_q30,
                                          output longint cos_q30);
    longint h;
    longint mag;
    longint zr;
    longint xr;
    longint yr;
    longint dx;
    longint dy;
    bit     flip;
    h = longint'(code);
    flip = 1'b0;
    if (h > ANG_HALF) h = h - ANG_FULL;
    else if (h < -ANG_HALF) h = h + ANG_FULL;
    if (h > ANG_QUARTER) begin
      h = ANG_HALF - h;
      flip = 1'b1;
    end else if (h < -ANG_QUARTER) begin
      h = -ANG_HALF - h;
      flip = 1'b1;
    end
    mag = (h < 0) ? -h : h;
    zr = (mag * PI_SCALED + ANG_QUARTER) / ANG_HALF;
    if (h < 0) zr = -zr;
    xr = CORDIC_K;
    yr = 0;
    for (int i = 0; i < N_STAGES && i < N_ATAN; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (zr >= 0) begin
        xr = xr - dx;
        yr = yr + dy;
        zr = zr - ARCTAN[i];
      end else begin
        xr = xr + dx;
        yr = yr - dy;
        zr = zr + ARCTAN[i];
      end
    end
    sin_q30 = yr;
    cos_q30 = flip ? -xr : xr;
  endfunction

  function automatic longint round_q30(input longint a, input longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic e2q_pkg::quat_t to_q15(input longint v60);
    longint r;
    r = (v60 + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > Q15_MAX) r = Q15_MAX;
    if (r < Q15_MIN) r = Q15_MIN;
    return e2q_pkg::quat_t'(r);
  endfunction

  function automatic quat_word_t predict_quat(input e2q_pkg::angle_t roll,
                                              input e2q_pkg::angle_t pitch,
                                              input e2q_pkg::angle_t yaw);
    longint     sr, cr, sp, cp, sy, cy;
    longint     crcp, srsp, srcp, crsp;
    quat_word_t q;
    half_angle_trig(roll, sr, cr);
    half_angle_trig(pitch, sp, cp);
    half_angle_trig(yaw, sy, cy);
    crcp = round_q30(cr, cp);
    srsp = round_q30(sr, sp);
    srcp = round_q30(sr, cp);
    crsp = round_q30(cr, sp);
    q.w = to_q15(crcp * cy + srsp * sy);
    q.x = to_q15(srcp * cy - crsp * sy);
    q.y = to_q15(crsp * cy + srcp * sy);
    q.z = to_q15(crcp * sy - srsp * cy);
    return q;
  endfunction

  function automatic e2q_pkg::angle_t pick_angle();
    e2q_pkg::angle_t specials[12];
    specials = '{16'sd0, 16'sd11520, -16'sd11520, 16'sd23040, -16'sd23040, 16'sd32767,
                 -16'sd32768, 16'sd1, -16'sd1, 16'sd23041, -16'sd23041, 16'sd11521};
    case ($urandom_range(9))
      7, 8: return e2q_pkg::angle_t'($urandom);
      9: return specials[$urandom_range(11)];
      default: return e2q_pkg::angle_t'(int'($urandom_range(46080)) - 23040);
    endcase
  endfunction

  task automatic queue_angles(input int roll, input int pitch, input int yaw,
                              input bit drain);
    angle_word_t a;
    a.roll = e2q_pkg::angle_t'(roll);
    a.pitch = e2q_pkg::angle_t'(pitch);
    a.yaw = e2q_pkg::angle_t'(yaw);
    a.drain = drain;
    angle_feed.push_back(a);
  endtask

  task automatic check_field(input string name, input e2q_pkg::quat_t want,
                             input e2q_pkg::quat_t got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: quat_%s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin : scoreboard
    quat_word_t want;
    bit         moved;
    in_took = 1'b0;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        quat_due.push_back(predict_quat(in_roll_deg, in_pitch_deg, in_yaw_deg));
        angle_feed.delete(0);
        in_took = 1'b1;
        moved = 1'b1;
        words_in++;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        words_out++;
        if (quat_due.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected quaternion word, actual %0d %0d %0d %0d", $time,
                   out_quat_w, out_quat_x, out_quat_y, out_quat_z);
        end else begin
          want = quat_due.pop_front();
          check_field("w", want.w, out_quat_w);
          check_field("x", want.x, out_quat_x);
          check_field("y", want.y, out_quat_y);
          check_field("z", want.z, out_quat_z);
        end
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // sender: bursts of words separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled word
    end else if (angle_feed.size() == 0) begin
      in_valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (angle_feed[0].drain && quat_due.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      if (angle_feed[0].drain) n_drains++;
      in_valid <= 1'b1;
      in_roll_deg <= angle_feed[0].roll;
      in_pitch_deg <= angle_feed[0].pitch;
      in_yaw_deg <= angle_feed[0].yaw;
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 1);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      end else begin
        burst_left--;
      end
    end
  end

  // receiver: stall pattern switches between modes
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3));
      rx_left = $urandom_range(200, 20);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE: out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(3) != 0);
      default: out_stall <= ((rx_left % 16) < 6);
    endcase
  end

  initial begin
    queue_angles(0, 0, 0, 1'b0);
    queue_angles(23040, 23040, 23040, 1'b0);
    queue_angles(-23040, -23040, -23040, 1'b0);
    queue_angles(32767, 32767, 32767, 1'b0);
    queue_angles(-32768, -32768, -32768, 1'b0);
    queue_angles(11520, 0, 0, 1'b0);
    queue_angles(0, 11520, 0, 1'b0);
    queue_angles(0, 0, 11520, 1'b0);
    queue_angles(-11520, -11520, -11520, 1'b0);
    queue_angles(11521, -11521, 5760, 1'b0);
    queue_angles(23041, -23041, 0, 1'b0);
    queue_angles(1, -1, 0, 1'b0);
    queue_angles(32767, -32768, 0, 1'b0);
    queue_angles(0, 32767, -32768, 1'b0);
    queue_angles(-32768, 0, 32767, 1'b0);
    queue_angles(23040, 0, -23040, 1'b0);
    queue_angles(21845, -21846, 5461, 1'b0);
    queue_angles(5760, 2880, -5760, 1'b0);
    queue_angles(-1, -1, -1, 1'b0);
    queue_angles(-11521, 11521, -23039, 1'b0);
    n_directed = angle_feed.size();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      queue_angles(pick_angle(), pick_angle(), pick_angle(),
                   (i == 0) || ($urandom_range(199) == 0));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (angle_feed.size() != 0 || in_valid) @(posedge clk);
    while (quat_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d angle words (%0d directed, %0d after a full drain); checked %0d",
             words_in, n_directed, n_drains, words_out);
    $display("quaternion words under bursty input and mixed output stall, %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
